/* hw/rtl/rag_pkg.sv */
// ----------------------------------------------------------------------------
// rag_pkg: shared types and constants
// Operation codes, state types and queue status for the rational GCD block.
// ----------------------------------------------------------------------------
package rag_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOAD,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TWO,
    B_GCD,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/rational_arith_gcd_reduce.sv */
// ----------------------------------------------------------------------------
// rational_arith_gcd_reduce: fraction arithmetic with GCD reduction
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the GCD of the numerator and denominator magnitudes.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o  | func, num_a, den_a, num_b, den_b
//  out     | output    | out_valid_o / out_stall_i| num_out, den_out, overflow, den_zero
//
// The front takes one beat at a time and forms each product in its
// shift-add multiplier: three products for add and subtract, two for
// multiply and divide. The back then runs the binary GCD and two restoring
// divisions, one for the numerator and one for the denominator. The
// two-entry queue lets the front work on the next beat while the back is
// busy. Reset clears all control state at once, and a stalled output
// simply holds the back in its output state.
//
module rational_arith_gcd_reduce import rag_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] num_a_i,
  input  logic signed [31:0] den_a_i,
  input  logic signed [31:0] num_b_i,
  input  logic signed [31:0] den_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] num_out_o,
  output logic signed [31:0] den_out_o,
  output logic               overflow_o,
  output logic               den_zero_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned QW = 2 * W + 1;

  logic [W-1:0]  na, da, nb, db, num_w, den_w;
  logic          push, pop;
  logic [QW-1:0] push_data, pop_data;
  q_status_t     q_status;

  // Inputs are sign-extended from 32 bits, or truncated, to the working width.
  assign na = W'(num_a_i);
  assign da = W'(den_a_i);
  assign nb = W'(num_b_i);
  assign db = W'(den_b_i);

  rag_front #(.DATA_WIDTH(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .num_a_i     (na),
    .den_a_i     (da),
    .num_b_i     (nb),
    .den_b_i     (db),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rag_queue #(.WIDTH(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  rag_back #(.DATA_WIDTH(W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .num_o       (num_w),
    .den_o       (den_w),
    .overflow_o  (overflow_o),
    .den_zero_o  (den_zero_o)
  );

  // Results leave as the low 32 bits of the working-width values.
  assign num_out_o = 32'(num_w);
  assign den_out_o = 32'(den_w);

endmodule

/* hw/rtl/rag_front.sv */
// ----------------------------------------------------------------------------
// rag_front: operand intake and raw fraction arithmetic
// Accepts a beat, forms the cross products with a shift-add multiplier and
// pushes the raw numerator, denominator and overflow flag to the queue.
// ----------------------------------------------------------------------------
module rag_front import rag_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                func_i,
  input  logic [DATA_WIDTH-1:0]     num_a_i,
  input  logic [DATA_WIDTH-1:0]     den_a_i,
  input  logic [DATA_WIDTH-1:0]     num_b_i,
  input  logic [DATA_WIDTH-1:0]     den_b_i,
  input  q_status_t                 q_status_i,
  output logic                      push_o,
  output logic [2*DATA_WIDTH:0]     push_data_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DATA_WIDTH);
  localparam logic [2*W-1:0] Sign = (2*W)'(1) << (W - 1);

  front_state_e state_q, state_d;
  func_e        func_q;
  logic [W-1:0]   na_q, da_q, nb_q, db_q;
  logic [1:0]     k_q;
  logic [2*W-1:0] acc_q, mc_q;
  logic [W-1:0]   mb_q;
  logic           neg_q;
  logic [CW-1:0]  cnt_q;
  logic           ovf_q;
  logic [W-1:0]   prod_q [3];

  logic [W-1:0]   op_x, op_y, mag_x, mag_y;
  logic [2*W-1:0] acc_nxt, limit;
  logic [W-1:0]   prod_val;
  logic           prod_ovf, last_prod, last_bit;
  logic [W-1:0]   n_raw, d_raw, sum;
  logic           add_ovf;

  // Operand pair for the product now being loaded.
  always_comb begin
    unique case (func_q)
      FUNC_ADD, FUNC_SUB: begin
        op_x = (k_q == 2'd0) ? na_q : (k_q == 2'd1) ? nb_q : da_q;
        op_y = (k_q == 2'd0) ? db_q : (k_q == 2'd1) ? da_q : db_q;
      end
      FUNC_MUL: begin
        op_x = (k_q == 2'd0) ? na_q : da_q;
        op_y = (k_q == 2'd0) ? nb_q : db_q;
      end
      default: begin
        op_x = (k_q == 2'd0) ? na_q : da_q;
        op_y = (k_q == 2'd0) ? db_q : nb_q;
      end
    endcase
  end

  assign mag_x     = op_x[W-1] ? (~op_x + W'(1)) : op_x;
  assign mag_y     = op_y[W-1] ? (~op_y + W'(1)) : op_y;
  assign acc_nxt   = acc_q + (mb_q[0] ? mc_q : '0);
  assign limit     = neg_q ? Sign : (Sign - (2*W)'(1));
  assign prod_ovf  = acc_nxt > limit;
  assign prod_val  = neg_q ? (~acc_nxt[W-1:0] + W'(1)) : acc_nxt[W-1:0];
  assign last_bit  = (cnt_q == CW'(W - 1));
  assign last_prod = ((func_q == FUNC_ADD) || (func_q == FUNC_SUB)) ?
                     (k_q == 2'd2) : (k_q == 2'd1);

  // Final numerator and denominator.
  always_comb begin
    sum     = '0;
    add_ovf = 1'b0;
    unique case (func_q)
      FUNC_ADD: begin
        sum     = prod_q[0] + prod_q[1];
        add_ovf = ~(prod_q[0][W-1] ^ prod_q[1][W-1]) & (prod_q[0][W-1] ^ sum[W-1]);
      end
      FUNC_SUB: begin
        sum     = prod_q[0] - prod_q[1];
        add_ovf = (prod_q[0][W-1] ^ prod_q[1][W-1]) & (prod_q[0][W-1] ^ sum[W-1]);
      end
      default: ;
    endcase
    if ((func_q == FUNC_ADD) || (func_q == FUNC_SUB)) begin
      n_raw = sum;
      d_raw = prod_q[2];
    end else begin
      n_raw = prod_q[0];
      d_raw = prod_q[1];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_LOAD;
      F_LOAD:  state_d = F_MUL;
      F_MUL:   if (last_bit) state_d = last_prod ? F_PUSH : F_LOAD;
      F_PUSH:  if (!q_status_i.full) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != F_IDLE);
    push_o      = (state_q == F_PUSH) && !q_status_i.full;
    push_data_o = {ovf_q | add_ovf, d_raw, n_raw};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        func_q <= func_e'(func_i);
        na_q   <= num_a_i;
        da_q   <= den_a_i;
        nb_q   <= num_b_i;
        db_q   <= den_b_i;
        k_q    <= 2'd0;
        ovf_q  <= 1'b0;
      end
      F_LOAD: begin
        acc_q <= '0;
        mc_q  <= (2*W)'(mag_x);
        mb_q  <= mag_y;
        neg_q <= op_x[W-1] ^ op_y[W-1];
        cnt_q <= '0;
      end
      F_MUL: begin
        acc_q <= acc_nxt;
        mc_q  <= mc_q << 1;
        mb_q  <= mb_q >> 1;
        cnt_q <= cnt_q + CW'(1);
        if (last_bit) begin
          prod_q[k_q] <= prod_val;
          ovf_q       <= ovf_q | prod_ovf;
          k_q         <= k_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/rag_queue.sv */
// ----------------------------------------------------------------------------
// rag_queue: short queue between front and back
// A small first-in first-out buffer of raw results.
// ----------------------------------------------------------------------------
module rag_queue import rag_pkg::*; #(
  parameter int unsigned WIDTH = 2 * DataWidthDef + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output q_status_t        status_o
);

  localparam int unsigned PW = $clog2(QueueDepth);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign status_o.full  = (cnt_q == (PW+1)'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

/* hw/rtl/rag_back.sv */
// ----------------------------------------------------------------------------
// rag_back: GCD reduction and result register
// Binary GCD of the magnitudes, then two restoring divisions by the GCD,
// signs restored, result held in an output register (zero values pass as is).
// ----------------------------------------------------------------------------
module rag_back import rag_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  q_status_t             q_status_i,
  input  logic [2*DATA_WIDTH:0] pop_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] num_o,
  output logic [DATA_WIDTH-1:0] den_o,
  output logic                  overflow_o,
  output logic                  den_zero_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DATA_WIDTH);

  back_state_e state_q, state_d;
  logic [W-1:0]  n_q, d_q, a_q, b_q, g_q, dvd_q, res_n_q, res_d_q;
  logic [W:0]    rem_q;
  logic [CW-1:0] k_q, cnt_q;
  logic          ovf_q, dz_q, sel_q, out_valid_q;

  logic [W-1:0] in_n, in_d, mag_n, mag_d, quo, quo_s;
  logic [W:0]   rem_sh;
  logic         ge, skip, last_bit;

  assign in_n     = pop_data_i[W-1:0];
  assign in_d     = pop_data_i[2*W-1:W];
  assign mag_n    = n_q[W-1] ? (~n_q + W'(1)) : n_q;
  assign mag_d    = d_q[W-1] ? (~d_q + W'(1)) : d_q;
  assign skip     = (in_n == '0) || (in_d == '0);
  assign rem_sh   = {rem_q[W-1:0], dvd_q[W-1]};
  assign ge       = rem_sh >= {1'b0, g_q};
  assign quo      = {dvd_q[W-2:0], ge};
  assign last_bit = (cnt_q == CW'(W - 1));
  // Negate the quotient back when the source value was negative.
  assign quo_s    = (sel_q ? d_q[W-1] : n_q[W-1]) ? (~quo + W'(1)) : quo;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!q_status_i.empty) state_d = skip ? B_OUT : B_TWO;
      B_TWO:   if (a_q[0] | b_q[0]) state_d = B_GCD;
      B_GCD:   if (a_q == b_q) state_d = B_DIV;
      B_DIV:   if (last_bit && sel_q) state_d = B_OUT;
      B_OUT:   if (!out_valid_q || !out_stall_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == B_IDLE) && !q_status_i.empty;
    out_valid_o = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == B_OUT) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        n_q     <= in_n;
        d_q     <= in_d;
        res_n_q <= in_n;
        res_d_q <= in_d;
        ovf_q   <= pop_data_i[2*W];
        dz_q    <= (in_d == '0);
        a_q     <= in_n[W-1] ? (~in_n + W'(1)) : in_n;
        b_q     <= in_d[W-1] ? (~in_d + W'(1)) : in_d;
        k_q     <= '0;
      end
      B_TWO: begin
        if (!(a_q[0] | b_q[0])) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          k_q <= k_q + CW'(1);
        end
      end
      B_GCD: begin
        if (a_q == b_q) begin
          g_q   <= a_q << k_q;
          dvd_q <= mag_n;
          rem_q <= '0;
          cnt_q <= '0;
          sel_q <= 1'b0;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= a_q - b_q;
        end else begin
          b_q <= b_q - a_q;
        end
      end
      B_DIV: begin
        rem_q <= ge ? (rem_sh - {1'b0, g_q}) : rem_sh;
        dvd_q <= quo;
        cnt_q <= cnt_q + CW'(1);
        if (last_bit) begin
          if (!sel_q) begin
            res_n_q <= quo_s;
            dvd_q   <= mag_d;
            rem_q   <= '0;
            cnt_q   <= '0;
            sel_q   <= 1'b1;
          end else begin
            res_d_q <= quo_s;
          end
        end
      end
      B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          num_o      <= res_n_q;
          den_o      <= res_d_q;
          overflow_o <= ovf_q;
          den_zero_o <= dz_q;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/rag_checker.sv */
// ----------------------------------------------------------------------------
// rag_checker: port-level checks
// Watches the top level's ports and flags illegal behavior over time.
// ----------------------------------------------------------------------------
module rag_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] den_out_o,
  input logic        den_zero_o
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A zero denominator is passed through unreduced, so it reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && den_zero_o |-> den_out_o == 32'd0)
    else $error("den_zero set with nonzero denominator");

  // Nothing is offered while reset is held.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

endmodule

bind rational_arith_gcd_reduce rag_checker u_rag_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .den_out_o   (den_out_o),
  .den_zero_o  (den_zero_o)
);
